/* hdl/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, register indexes and the Horner beat type of the
// polynomial pixel map.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int NUM_COEFFS = 9;
  localparam int DEG_W      = 4;
  localparam int RECIP_W    = 33;
  localparam int FRAC_W     = 24;
  localparam int X_W        = FRAC_W + 1;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = ACC_W + X_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [X_W-1:0] ONE_Q24 = X_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_01    = 3'd0,
    CFG_COEFF_23    = 3'd1,
    CFG_COEFF_45    = 3'd2,
    CFG_COEFF_67    = 3'd3,
    CFG_COEFF_TOP   = 3'd4,
    CFG_POLY_DEGREE = 3'd5,
    CFG_FULL_SCALE  = 3'd6,
    CFG_FULL_RECIP  = 3'd7
  } cfg_idx_e;

  // normalized sample and running Horner sum, Q1.24 and widened Q16.24
  typedef struct packed {
    logic [X_W-1:0]          x;
    logic signed [ACC_W-1:0] acc;
  } horner_beat_t;

endpackage

/* hdl/ppm_norm.sv */
// ----------------------------------------------------------------------------
// ppm_norm
// Saturates the sample to full scale and normalizes it with the reciprocal,
// two pipeline stages.
// ----------------------------------------------------------------------------
module ppm_norm
  import ppm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] full_scale_i,
  input  logic [RECIP_W-1:0]  recip_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [X_W-1:0]      x_o
);

  localparam int NPROD_W = SAMPLE_W + RECIP_W;
  localparam int SHIFT   = RECIP_W - 1 - FRAC_W;

  logic                 a_valid_q, b_valid_q;
  logic                 a_ready, b_ready;
  logic [SAMPLE_W-1:0]  sat_sample;
  logic [NPROD_W-1:0]   prod_d, prod_q;
  logic [NPROD_W-SHIFT-1:0] shifted;
  logic [X_W-1:0]       x_d, x_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign sat_sample = (sample_i > full_scale_i) ? full_scale_i : sample_i;
  assign prod_d     = NPROD_W'(sat_sample) * NPROD_W'(recip_i);

  assign shifted = prod_q[NPROD_W-1:SHIFT];
  assign x_d     = (shifted > (NPROD_W-SHIFT)'(ONE_Q24)) ? ONE_Q24 : shifted[X_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) prod_q <= prod_d;
    if (b_ready && a_valid_q) x_q <= x_d;
  end

  assign out_valid_o = b_valid_q;
  assign x_o         = x_q;

endmodule

/* hdl/ppm_horner_cell.sv */
// ----------------------------------------------------------------------------
// ppm_horner_cell
// One Horner step: acc = sat40(round(acc * x) + c), multiply stage then
// round, add and saturate stage.
// ----------------------------------------------------------------------------
module ppm_horner_cell
  import ppm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  horner_beat_t             in_beat_i,
  input  logic signed [COEF_W-1:0] coeff_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output horner_beat_t             out_beat_o
);

  localparam int RND_W = PROD_W - FRAC_W;
  localparam int SUM_W = RND_W + 2;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-(64'sd1 <<< (ACC_W - 1)));

  logic                    a_valid_q, b_valid_q;
  logic                    a_ready, b_ready;
  logic [ACC_W-1:0]        mag;
  logic [PROD_W-1:0]       prod_d, prod_q;
  logic                    neg_q;
  logic [X_W-1:0]          x_a_q;
  logic [PROD_W-1:0]       rounded;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum;
  horner_beat_t            beat_d, beat_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // sign and magnitude, so rounding ties go away from zero
  assign mag    = in_beat_i.acc[ACC_W-1] ? ACC_W'(-in_beat_i.acc) : ACC_W'(in_beat_i.acc);
  assign prod_d = PROD_W'(mag) * PROD_W'(in_beat_i.x);

  assign rounded = prod_q + (PROD_W'(1) << (FRAC_W - 1));
  assign term    = neg_q ? -$signed(SUM_W'(rounded[PROD_W-1:FRAC_W]))
                         : $signed(SUM_W'(rounded[PROD_W-1:FRAC_W]));
  assign sum     = term + SUM_W'(coeff_i);

  always_comb begin
    beat_d.x = x_a_q;
    priority if (sum > ACC_MAX) begin
      beat_d.acc = ACC_MAX[ACC_W-1:0];
    end else if (sum < ACC_MIN) begin
      beat_d.acc = ACC_MIN[ACC_W-1:0];
    end else begin
      beat_d.acc = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      prod_q <= prod_d;
      neg_q  <= in_beat_i.acc[ACC_W-1];
      x_a_q  <= in_beat_i.x;
    end
    if (b_ready && a_valid_q) beat_q <= beat_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_beat_o  = beat_q;

endmodule

/* hdl/ppm_out.sv */
// ----------------------------------------------------------------------------
// ppm_out
// Clamps the polynomial to [0,1], scales by full scale and rounds to the
// 16-bit output sample, two pipeline stages.
// ----------------------------------------------------------------------------
module ppm_out
  import ppm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic [SAMPLE_W-1:0]     full_scale_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SAMPLE_W-1:0]     sample_o
);

  localparam int SCALE_W = X_W + SAMPLE_W;

  logic                a_valid_q, b_valid_q;
  logic                a_ready, b_ready;
  logic [X_W-1:0]      y_d, y_q;
  logic [SCALE_W-1:0]  scaled;
  logic [SAMPLE_W-1:0] sample_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    priority if (acc_i[ACC_W-1]) begin
      y_d = '0;
    end else if (acc_i > $signed(ACC_W'(ONE_Q24))) begin
      y_d = ONE_Q24;
    end else begin
      y_d = acc_i[X_W-1:0];
    end
  end

  assign scaled = SCALE_W'(y_q) * SCALE_W'(full_scale_i) + (SCALE_W'(1) << (FRAC_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) y_q <= y_d;
    if (b_ready && a_valid_q) sample_q <= scaled[FRAC_W+SAMPLE_W-1:FRAC_W];
  end

  assign out_valid_o = b_valid_q;
  assign sample_o    = sample_q;

endmodule

/* hdl/polynomial_pixel_map_top.sv */
// ----------------------------------------------------------------------------
// polynomial_pixel_map_top
// Maps 16-bit pixel samples through a configured fixed-point polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel sample per transaction, m_axis one mapped sample.
//   Coefficients, degree, full scale and its reciprocal are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no sample is in flight.
//   The datapath is a chain of MAX_DEGREE Horner cells between a two-stage
//   normalizer and a two-stage clamp and scale stage; each cell has a
//   multiply register and a round/add/saturate register.
//   Throughput: one sample per cycle while the receiver is ready; stalls hold stages.
//   Each stage has its own valid bit, so bubbles collapse: when the receiver
//   stalls, samples pile up in empty stages and s_axis_tready only drops
//   once every stage is full.
//   Reset empties the pipeline and returns the registers to their reset
//   values: zero coefficients, degree 1, full scale 65535, reciprocal 65537.
// ----------------------------------------------------------------------------
module polynomial_pixel_map_top
  import ppm_pkg::*;
#(
  parameter int MAX_DEGREE = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata    // [15:0] sample_out
);

  localparam int NUM_STAGES = 2 * MAX_DEGREE + 4;
  localparam int CNT_W      = $clog2(NUM_STAGES + 1);

  logic [COEF_W-1:0]   coef_q [NUM_COEFFS];
  logic [DEG_W-1:0]    degree_q;
  logic [SAMPLE_W-1:0] full_scale_q;
  logic [RECIP_W-1:0]  recip_q;

  logic [DEG_W-1:0]         degree_eff;
  logic signed [COEF_W-1:0] coef_eff [MAX_DEGREE+1];

  logic               norm_valid, norm_ready;
  logic [X_W-1:0]     norm_x;
  logic               chain_valid [MAX_DEGREE+1];
  logic               chain_ready [MAX_DEGREE+1];
  horner_beat_t       chain_beat  [MAX_DEGREE+1];

  logic [CNT_W-1:0]   inflight_q, inflight_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFFS; i++) coef_q[i] <= '0;
      degree_q     <= DEG_W'(1);
      full_scale_q <= SAMPLE_W'(65535);
      recip_q      <= RECIP_W'(65537);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COEFF_01: begin
          coef_q[0] <= cfg_wdata_i[31:0];
          coef_q[1] <= cfg_wdata_i[63:32];
        end
        CFG_COEFF_23: begin
          coef_q[2] <= cfg_wdata_i[31:0];
          coef_q[3] <= cfg_wdata_i[63:32];
        end
        CFG_COEFF_45: begin
          coef_q[4] <= cfg_wdata_i[31:0];
          coef_q[5] <= cfg_wdata_i[63:32];
        end
        CFG_COEFF_67: begin
          coef_q[6] <= cfg_wdata_i[31:0];
          coef_q[7] <= cfg_wdata_i[63:32];
        end
        CFG_COEFF_TOP:   coef_q[8]    <= cfg_wdata_i[31:0];
        CFG_POLY_DEGREE: degree_q     <= cfg_wdata_i[DEG_W-1:0];
        CFG_FULL_SCALE:  full_scale_q <= cfg_wdata_i[SAMPLE_W-1:0];
        CFG_FULL_RECIP:  recip_q      <= cfg_wdata_i[RECIP_W-1:0];
      endcase
    end
  end

  // coefficients above the degree read as zero, so every cell runs the same step
  assign degree_eff = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

  always_comb begin
    for (int k = 0; k <= MAX_DEGREE; k++) begin
      coef_eff[k] = (DEG_W'(k) <= degree_eff) ? $signed(coef_q[k]) : '0;
    end
  end

  ppm_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata),
    .full_scale_i (full_scale_q),
    .recip_i      (recip_q),
    .out_valid_o  (norm_valid),
    .out_ready_i  (norm_ready),
    .x_o          (norm_x)
  );

  assign chain_valid[0]    = norm_valid;
  assign norm_ready        = chain_ready[0];
  assign chain_beat[0].x   = norm_x;
  assign chain_beat[0].acc = ACC_W'(coef_eff[MAX_DEGREE]);

  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
    ppm_horner_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[j]),
      .in_ready_o  (chain_ready[j]),
      .in_beat_i   (chain_beat[j]),
      .coeff_i     (coef_eff[MAX_DEGREE-1-j]),
      .out_valid_o (chain_valid[j+1]),
      .out_ready_i (chain_ready[j+1]),
      .out_beat_o  (chain_beat[j+1])
    );
  end

  ppm_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (chain_valid[MAX_DEGREE]),
    .in_ready_o   (chain_ready[MAX_DEGREE]),
    .acc_i        (chain_beat[MAX_DEGREE].acc),
    .full_scale_i (full_scale_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sample_o     (m_axis_tdata)
  );

  // transactions in flight, used only by the occupancy assertions below
  always_comb begin
    inflight_d = inflight_q;
    if (s_axis_tvalid && s_axis_tready) inflight_d = inflight_d + CNT_W'(1);
    if (m_axis_tvalid && m_axis_tready) inflight_d = inflight_d - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the receiver is ready");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(NUM_STAGES))
    else $error("more transactions in flight than pipeline stages");

  a_no_phantom_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> !m_axis_tvalid)
    else $error("output valid with no transaction in flight");

  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == CNT_W'(NUM_STAGES)) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while every stage is full");
`endif

endmodule
